@@ design/bbs_pkg.sv @@
// shared types and constants for the bounding box and sphere unit
package bbs_pkg;

    localparam int NUM_REGS = 6;
    localparam int CFG_IDX_W = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam logic signed [31:0] BOX_START = 32'sd655360000;

    localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS01 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS23 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS01 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS23 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS01 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS23 = 3'd5;

    localparam logic KIND_BOX    = 1'b0;
    localparam logic KIND_SPHERE = 1'b1;

    // transformed vertex as passed from front to back
    typedef struct packed {
        logic              kind;
        logic              first;
        logic              last;
        logic signed [31:0] qx;
        logic signed [31:0] qy;
        logic signed [31:0] qz;
    } vtx_t;

    typedef struct packed {
        logic              kind;
        logic signed [31:0] min_x;
        logic signed [31:0] min_y;
        logic signed [31:0] min_z;
        logic signed [31:0] max_x;
        logic signed [31:0] max_y;
        logic signed [31:0] max_z;
        logic [31:0]       radius;
    } res_t;

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        if (v > 50'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -50'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage

@@ design/bbs_front.sv @@
// front part: vertex transform pipeline, three stages
module bbs_front
    import bbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        kind,
    input  logic        first,
    input  logic        last,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [31:0] pos_z,
    input  logic [63:0] cfg_regs [NUM_REGS],
    output logic        out_valid,
    output vtx_t        out_vtx
);

    logic               s1_valid_reg;
    logic               s1_kind_reg, s1_first_reg, s1_last_reg;
    logic signed [63:0] s1_prod_reg [3][3];
    logic               s2_valid_reg;
    logic               s2_kind_reg, s2_first_reg, s2_last_reg;
    logic signed [49:0] s2_sum_reg [3];
    logic signed [31:0] pos [3];

    assign pos[0] = pos_x;
    assign pos[1] = pos_y;
    assign pos[2] = pos_z;

    // stage 1: nine 32x32 products
    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            s1_prod_reg[r][0] <= $signed(cfg_regs[2*r][31:0]) * pos[0];
            s1_prod_reg[r][1] <= $signed(cfg_regs[2*r][63:32]) * pos[1];
            s1_prod_reg[r][2] <= $signed(cfg_regs[2*r+1][31:0]) * pos[2];
        end
        s1_kind_reg  <= kind;
        s1_first_reg <= first;
        s1_last_reg  <= last;
    end

    // stage 2: exact sum then floor (arithmetic shift floors), then add the offset
    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            s2_sum_reg[r] <= 50'(((66'(s1_prod_reg[r][0]) + 66'(s1_prod_reg[r][1])
                              + 66'(s1_prod_reg[r][2])) >>> 16))
                             + 50'($signed(cfg_regs[2*r+1][63:32]));
        end
        s2_kind_reg  <= s1_kind_reg;
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
    end

    always_ff @(posedge clk)
    begin
        out_vtx.qx    <= sat32(s2_sum_reg[0]);
        out_vtx.qy    <= sat32(s2_sum_reg[1]);
        out_vtx.qz    <= sat32(s2_sum_reg[2]);
        out_vtx.kind  <= s2_kind_reg;
        out_vtx.first <= s2_first_reg;
        out_vtx.last  <= s2_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            out_valid    <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            out_valid    <= s2_valid_reg;
        end
    end

endmodule

@@ design/bbs_back.sv @@
// back part: box accumulate, distance accumulate, square root
module bbs_back
    import bbs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  vtx_t  in_vtx,
    output logic  in_ready,
    output logic  res_valid,
    output res_t  res,
    input  logic  res_ready
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_DIFF = 6'b000010,
        ST_SQ   = 6'b000100,
        ST_ACC  = 6'b001000,
        ST_SQRT = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic signed [31:0] lo_reg [3];
    logic signed [31:0] hi_reg [3];
    logic signed [31:0] ctr_reg [3];
    logic [63:0]        best_reg;
    vtx_t               v_reg;
    logic [32:0]        ad_reg [3];
    logic [63:0]        sq_reg [3];
    logic [63:0]        rem_reg, root_reg, bit_reg;
    logic signed [31:0] q [3];
    logic signed [31:0] lo_new [3];
    logic signed [31:0] hi_new [3];
    logic [65:0]        sum_w;
    logic [63:0]        dist_sq;
    logic [63:0]        cur_best;

    assign in_ready = (state_reg == ST_IDLE) && !res_valid;
    assign q[0] = in_vtx.qx;
    assign q[1] = in_vtx.qy;
    assign q[2] = in_vtx.qz;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            lo_new[i] = in_vtx.first ? BOX_START : lo_reg[i];
            hi_new[i] = in_vtx.first ? -BOX_START : hi_reg[i];
            if (q[i] < lo_new[i]) lo_new[i] = q[i];
            if (q[i] > hi_new[i]) hi_new[i] = q[i];
        end
        sum_w = 66'(sq_reg[0]) + 66'(sq_reg[1]) + 66'(sq_reg[2]);
        dist_sq  = (sum_w[65:64] != 2'b00) ? '1 : sum_w[63:0];
        cur_best = v_reg.first ? 64'd0 : best_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid && in_ready && in_vtx.kind == KIND_SPHERE)
                    state_next = ST_DIFF;
            ST_DIFF: state_next = ST_SQ;
            ST_SQ:   state_next = ST_ACC;
            ST_ACC:  state_next = v_reg.last ? ST_SQRT : ST_IDLE;
            ST_SQRT: if (bit_reg == 64'd0) state_next = ST_OUT;
            ST_OUT:  if (!res_valid) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            res_valid <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                lo_reg[i]  <= BOX_START;
                hi_reg[i]  <= -BOX_START;
                ctr_reg[i] <= '0;
            end
            best_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (res_valid && res_ready)
                res_valid <= 1'b0;
            if (state_reg == ST_IDLE && in_valid && in_ready)
            begin
                v_reg <= in_vtx;
                if (in_vtx.kind == KIND_BOX)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        lo_reg[i] <= lo_new[i];
                        hi_reg[i] <= hi_new[i];
                        if (in_vtx.last)
                            ctr_reg[i] <= 32'((33'(lo_new[i]) + 33'(hi_new[i])) >>> 1);
                    end
                    if (in_vtx.last)
                    begin
                        res_valid  <= 1'b1;
                        res.kind   <= KIND_BOX;
                        res.min_x  <= lo_new[0];
                        res.min_y  <= lo_new[1];
                        res.min_z  <= lo_new[2];
                        res.max_x  <= hi_new[0];
                        res.max_y  <= hi_new[1];
                        res.max_z  <= hi_new[2];
                        res.radius <= '0;
                    end
                end
            end
            if (state_reg == ST_DIFF)
            begin
                ad_reg[0] <= ($signed(33'(v_reg.qx) - 33'(ctr_reg[0])) < 0)
                    ? 33'(-(33'(v_reg.qx) - 33'(ctr_reg[0]))) : 33'(v_reg.qx) - 33'(ctr_reg[0]);
                ad_reg[1] <= ($signed(33'(v_reg.qy) - 33'(ctr_reg[1])) < 0)
                    ? 33'(-(33'(v_reg.qy) - 33'(ctr_reg[1]))) : 33'(v_reg.qy) - 33'(ctr_reg[1]);
                ad_reg[2] <= ($signed(33'(v_reg.qz) - 33'(ctr_reg[2])) < 0)
                    ? 33'(-(33'(v_reg.qz) - 33'(ctr_reg[2]))) : 33'(v_reg.qz) - 33'(ctr_reg[2]);
            end
            // squares land in sq_reg at the end of ST_SQ; ST_ACC then compares them
            if (state_reg == ST_ACC)
            begin
                best_reg <= (dist_sq > cur_best) ? dist_sq : cur_best;
                rem_reg  <= (dist_sq > cur_best) ? dist_sq : cur_best;
                root_reg <= '0;
                bit_reg  <= 64'h4000_0000_0000_0000;
            end
            if (state_reg == ST_SQRT && bit_reg != 64'd0)
            begin
                if (rem_reg >= root_reg + bit_reg)
                begin
                    rem_reg  <= rem_reg - (root_reg + bit_reg);
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                    root_reg <= root_reg >> 1;
                bit_reg <= bit_reg >> 2;
            end
            if (state_reg == ST_OUT && !res_valid)
            begin
                res_valid  <= 1'b1;
                res.kind   <= KIND_SPHERE;
                res.min_x  <= '0;
                res.min_y  <= '0;
                res.min_z  <= '0;
                res.max_x  <= '0;
                res.max_y  <= '0;
                res.max_z  <= '0;
                res.radius <= root_reg[31:0];
            end
        end
    end

    // squares: one 33x33 product each, registered
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            sq_reg[i] <= 64'(66'(ad_reg[i]) * 66'(ad_reg[i]));
    end

endmodule

@@ design/bbs_queue.sv @@
// small vertex queue between front and back
module bbs_queue
    import bbs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  vtx_t wr_data,
    output logic rd_valid,
    output vtx_t rd_data,
    input  logic rd_en,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    vtx_t            mem_reg [DEPTH];
    logic [AW-1:0]   wp_reg, rp_reg;
    logic [$clog2(DEPTH+1)-1:0] cnt_reg;

    assign rd_valid = cnt_reg != '0;
    assign rd_data  = mem_reg[rp_reg];
    assign count    = cnt_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (rd_en)
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (wr_en ? 1'b1 : 1'b0) - (rd_en ? 1'b1 : 1'b0);
        end
    end

endmodule

@@ design/bounding_box_and_sphere.sv @@
// top level of the bounding box and bounding sphere unit
// Vertices enter through a push/full queue port and pass a three-stage
// transform pipeline (the front), then wait in a small queue for the back,
// which keeps the box min/max for box vertices and steps each sphere vertex
// through accept, difference, square and compare states. A sphere pass's
// last vertex then runs a bit-pair square root of 32 steps, a finish step
// and an output state that loads the radius result. With the back idle and
// no result waiting, the back takes the last box vertex once it has passed
// the three front stages and the queue, and registers the box result as it
// takes it. The input is held full while the transform pipeline plus queue
// could not absorb more items. Results are shown on the pop side until
// popped; a new result waits for the previous one to be taken, and while a
// result waits the back takes no vertex. No clearing pass follows reset.
module bounding_box_and_sphere
    import bbs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        kind,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [31:0] pos_z,
    input  logic        first,
    input  logic        last,
    output logic        empty,
    input  logic        pop,
    output logic        result_kind,
    output logic [31:0] min_x,
    output logic [31:0] min_y,
    output logic [31:0] min_z,
    output logic [31:0] max_x,
    output logic [31:0] max_y,
    output logic [31:0] max_z,
    output logic [31:0] radius,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int CW = $clog2(DEPTH+1);

    logic [63:0] cfg_regs_reg [NUM_REGS];
    logic        fr_valid;
    vtx_t        fr_vtx;
    logic        q_valid;
    vtx_t        q_data;
    logic        bk_ready;
    logic [CW-1:0] q_count;
    logic [2:0]  pipe_reg;
    logic        accept;
    logic        res_valid;
    res_t        res;

    assign accept = push && !full;
    // in-flight transform items plus queued ones must fit in the queue
    assign full = (32'(q_count) + 32'(pipe_reg[0]) + 32'(pipe_reg[1]) + 32'(pipe_reg[2]))
                  >= DEPTH;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_reg <= '0;
            cfg_regs_reg[REG_ROW0_COLS01] <= 64'd65536;
            cfg_regs_reg[REG_ROW0_COLS23] <= 64'd0;
            cfg_regs_reg[REG_ROW1_COLS01] <= 64'd65536 << 32;
            cfg_regs_reg[REG_ROW1_COLS23] <= 64'd0;
            cfg_regs_reg[REG_ROW2_COLS01] <= 64'd0;
            cfg_regs_reg[REG_ROW2_COLS23] <= 64'd65536;
        end
        else
        begin
            pipe_reg <= {pipe_reg[1:0], accept};
            // writes beyond the last register are dropped
            if (cfg_valid && 32'(cfg_index) < NUM_REGS)
                cfg_regs_reg[cfg_index] <= cfg_data;
        end
    end

    bbs_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(accept),
        .kind(kind), .first(first), .last(last),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .cfg_regs(cfg_regs_reg), .out_valid(fr_valid), .out_vtx(fr_vtx)
    );

    bbs_queue #(.DEPTH(DEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n), .wr_en(fr_valid), .wr_data(fr_vtx),
        .rd_valid(q_valid), .rd_data(q_data), .rd_en(q_valid && bk_ready),
        .count(q_count)
    );

    bbs_back u_back (
        .clk(clk), .rst_n(rst_n), .in_valid(q_valid), .in_vtx(q_data),
        .in_ready(bk_ready), .res_valid(res_valid), .res(res),
        .res_ready(pop)
    );

    assign empty       = !res_valid;
    assign result_kind = res.kind;
    assign min_x       = res.min_x;
    assign min_y       = res.min_y;
    assign min_z       = res.min_z;
    assign max_x       = res.max_x;
    assign max_y       = res.max_y;
    assign max_z       = res.max_z;
    assign radius      = res.radius;

endmodule

@@ design/bbs_checker.sv @@
// port-level checker for the bounding box and sphere unit
module bbs_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic        result_kind,
    input logic [31:0] min_x,
    input logic [31:0] radius
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(radius) && $stable(result_kind)))
        else $error("result changed while waiting");

    a_box_rad: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_kind == 1'b0) |-> (radius == 32'd0))
        else $error("box result with nonzero radius");

    a_sph_box: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_kind == 1'b1) |-> (min_x == 32'd0))
        else $error("sphere result with nonzero box field");

    a_reset: assert property (@(posedge clk) $fell(rst_n) |-> ##1 empty)
        else $error("result after reset");

endmodule

bind bounding_box_and_sphere bbs_checker u_bbs_checker (
    .clk(clk), .rst_n(rst_n), .empty(empty), .pop(pop),
    .result_kind(result_kind), .min_x(min_x), .radius(radius)
);
